/* sv/tsin_pkg.sv */
package tsin_pkg;

   // field widths
   localparam int ANGLE_W = 31;
   localparam int TOL_W   = 31;
   localparam int SINE_W  = 32;
   localparam int CNT_W   = 6;
   localparam int STAT_W  = 2;

   // internal Q.30 widths
   localparam int XW     = 42;
   localparam int MAG_W  = 32;
   localparam int TERM_W = 34;
   localparam int SQ_W   = 34;
   localparam int HALF_W = 17;
   localparam int PROD_W = 68;
   localparam int NUM_W  = 40;
   localparam int SUM_W  = 40;

   // reduction by 2*pi: one restoring step per power of two, 2^7 down to 2^0
   localparam int RED_STEPS = 8;
   localparam int SHIFT_W   = 3;

   localparam int MAX_TERMS_DEF = 16;

   localparam logic [XW-1:0] TWO_PI_Q30 = 42'd6746518852;
   localparam logic [XW-1:0] LIM_Q30    = 42'd3480633608;
   localparam logic signed [SUM_W-1:0] ONE_Q30 = 40'sd1073741824;
   localparam logic signed [ANGLE_W-1:0] LIMIT_Q20 = 31'sd1048576000;
   localparam logic [TOL_W-1:0] TOL_RESET = 31'd1074;

   // status codes
   localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_RANGE = 2'd1;
   localparam logic [STAT_W-1:0] STAT_TOL   = 2'd2;

   typedef struct packed {
      logic                load;
      logic                eval;
      logic                reduce;
      logic [SHIFT_W-1:0]  shift;
      logic                fixup;
      logic                square;
      logic                check;
      logic                mul_lo;
      logic                mul_hi;
      logic                div_load;
      logic                div_step;
      logic                div_done;
      logic                emit;
   } tsin_cmd_type;

   typedef struct packed {
      logic err;
      logic go;
      logic out_free;
   } tsin_stat_type;

endpackage

/* sv/tsin_ctrl.sv */
module tsin_ctrl import tsin_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_stall,
   input  tsin_stat_type st,
   output tsin_cmd_type  cmd
);

   localparam int DIV_STEPS = NUM_W / 2;
   localparam int DC_W = $clog2(DIV_STEPS);
   localparam logic [DC_W-1:0] DIV_LAST = DC_W'(DIV_STEPS - 1);

   localparam logic [3:0] S_IDLE     = 4'd0;
   localparam logic [3:0] S_EVAL     = 4'd1;
   localparam logic [3:0] S_REDUCE   = 4'd2;
   localparam logic [3:0] S_FIXUP    = 4'd3;
   localparam logic [3:0] S_SQUARE   = 4'd4;
   localparam logic [3:0] S_CHECK    = 4'd5;
   localparam logic [3:0] S_MUL_LO   = 4'd6;
   localparam logic [3:0] S_MUL_HI   = 4'd7;
   localparam logic [3:0] S_DIV_LOAD = 4'd8;
   localparam logic [3:0] S_DIV      = 4'd9;
   localparam logic [3:0] S_DIV_END  = 4'd10;
   localparam logic [3:0] S_FINISH   = 4'd11;

   logic [3:0]         state_ff, state_in;
   logic [SHIFT_W-1:0] red_ff, red_in;
   logic [DC_W-1:0]    div_ff, div_in;

   assign req_stall = (state_ff != S_IDLE);

   // sequence one item through the datapath
   always_comb begin
      state_in = state_ff;
      red_in   = red_ff;
      div_in   = div_ff;
      cmd      = '0;
      cmd.shift = red_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_EVAL;
            end
         end
         S_EVAL: begin
            if (st.err) begin
               state_in = S_FINISH;
            end else begin
               cmd.eval = 1'b1;
               red_in   = SHIFT_W'(RED_STEPS - 1);
               state_in = S_REDUCE;
            end
         end
         S_REDUCE: begin
            cmd.reduce = 1'b1;
            if (red_ff == '0) state_in = S_FIXUP;
            else red_in = red_ff - 1'b1;
         end
         S_FIXUP: begin
            cmd.fixup = 1'b1;
            state_in  = S_SQUARE;
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = S_CHECK;
         end
         S_CHECK: begin
            cmd.check = 1'b1;
            state_in  = st.go ? S_MUL_LO : S_FINISH;
         end
         S_MUL_LO: begin
            cmd.mul_lo = 1'b1;
            state_in   = S_MUL_HI;
         end
         S_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = S_DIV_LOAD;
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            div_in       = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (div_ff == DIV_LAST) state_in = S_DIV_END;
            else div_in = div_ff + 1'b1;
         end
         S_DIV_END: begin
            cmd.div_done = 1'b1;
            state_in     = S_CHECK;
         end
         S_FINISH: begin
            if (st.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         red_ff   <= '0;
         div_ff   <= '0;
      end else begin
         state_ff <= state_in;
         red_ff   <= red_in;
         div_ff   <= div_in;
      end
   end

endmodule

/* sv/tsin_dp.sv */
module tsin_dp import tsin_pkg::*; #(
   parameter int MAX_TERMS = MAX_TERMS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  tsin_cmd_type                cmd,
   output tsin_stat_type               st,
   input  logic signed [ANGLE_W-1:0]   req_angle,
   input  logic                        csr_valid,
   input  logic [TOL_W-1:0]            csr_tolerance,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic signed [SINE_W-1:0]    rsp_sine_value,
   output logic [CNT_W-1:0]            rsp_terms_used,
   output logic [STAT_W-1:0]           rsp_status
);

   // divisor (2k+2)(2k+3) for the last term index k = MAX_TERMS-1
   localparam int DW = $clog2(2 * MAX_TERMS * (2 * MAX_TERMS + 1) + 1);

   logic [TOL_W-1:0]         tol_ff;
   logic signed [XW-1:0]     x_ff;
   logic [STAT_W-1:0]        err_ff;
   logic [XW-1:0]            r_ff;
   logic                     big_ff;
   logic                     neg_ff;
   logic [MAG_W-1:0]         mag_ff;
   logic [SQ_W-1:0]          sq_ff;
   logic [TERM_W-1:0]        term_ff;
   logic signed [SUM_W-1:0]  sum_ff;
   logic [CNT_W-1:0]         cnt_ff;
   logic [PROD_W-1:0]        acc_ff;
   logic [NUM_W-1:0]         num_ff;
   logic [DW-1:0]            rem_ff;
   logic                     rsp_valid_ff;
   logic signed [SINE_W-1:0] sine_ff;
   logic [CNT_W-1:0]         terms_ff;
   logic [STAT_W-1:0]        status_ff;

   logic [XW-1:0]            m;
   logic [XW-1:0]            sub;
   logic signed [XW-1:0]     red_s, red_v;
   logic [2*MAG_W-1:0]       sq_prod;
   logic [TERM_W+HALF_W-1:0] part_prod;
   logic [DW-1:0]            d;
   logic [2*CNT_W:0]         d_wide;
   logic [DW:0]              r1, r2;
   logic                     b1, b2;
   logic [DW-1:0]            r1s, r2s;
   logic [PROD_W-1:0]        rnd;
   logic signed [SUM_W-1:0]  sat;
   logic [STAT_W-1:0]        err_in;

   // classify the incoming request: zero tolerance, angle out of range, or ok
   always_comb begin
      if (tol_ff == '0) err_in = STAT_TOL;
      else if (req_angle >= LIMIT_Q20 || req_angle <= -LIMIT_Q20) err_in = STAT_RANGE;
      else err_in = STAT_OK;
   end

   assign m   = x_ff[XW-1] ? XW'(-x_ff) : XW'(x_ff);
   assign sub = TWO_PI_Q30 << cmd.shift;

   // fold back into the window around zero
   always_comb begin
      red_s = big_ff ? signed'(LIM_Q30 + XW'(1) + r_ff - TWO_PI_Q30) : signed'(m);
      red_v = x_ff[XW-1] ? -red_s : red_s;
   end

   assign sq_prod = mag_ff * mag_ff;

   // shared multiplier: term times the low or the high half of x^2
   assign part_prod = term_ff * (cmd.mul_hi ? sq_ff[SQ_W-1:HALF_W] : sq_ff[HALF_W-1:0]);

   // divisor for term index k
   assign d_wide = (2*CNT_W+1)'({cnt_ff, 1'b0} + 2'd2) * (2*CNT_W+1)'({cnt_ff, 1'b0} + 2'd3);
   assign d      = d_wide[DW-1:0];

   // two quotient bits per cycle
   always_comb begin
      r1  = {rem_ff, num_ff[NUM_W-1]};
      b1  = (r1 >= {1'b0, d});
      r1s = b1 ? DW'(r1 - {1'b0, d}) : DW'(r1);
      r2  = {r1s, num_ff[NUM_W-2]};
      b2  = (r2 >= {1'b0, d});
      r2s = b2 ? DW'(r2 - {1'b0, d}) : DW'(r2);
   end

   assign rnd = acc_ff + (PROD_W'(1) << 29);

   always_comb begin
      if (sum_ff > ONE_Q30) sat = ONE_Q30;
      else if (sum_ff < -ONE_Q30) sat = -ONE_Q30;
      else sat = sum_ff;
   end

   assign st.err      = (err_ff != STAT_OK);
   assign st.go       = (term_ff >= TERM_W'(tol_ff)) && (cnt_ff < CNT_W'(MAX_TERMS));
   assign st.out_free = !rsp_valid_ff || !rsp_stall;

   // tolerance register
   always_ff @(posedge clock) begin
      if (reset) tol_ff <= TOL_RESET;
      else if (csr_valid) tol_ff <= csr_tolerance;
   end

   // working registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         x_ff   <= XW'(req_angle) <<< 10;
         err_ff <= err_in;
      end
      if (cmd.eval) begin
         r_ff   <= m - LIM_Q30 - XW'(1);
         big_ff <= (m > LIM_Q30);
      end
      if (cmd.reduce && r_ff >= sub) r_ff <= r_ff - sub;
      if (cmd.fixup) begin
         neg_ff <= red_v[XW-1];
         mag_ff <= red_v[XW-1] ? MAG_W'(-red_v) : MAG_W'(red_v);
      end
      if (cmd.square) begin
         sq_ff   <= SQ_W'((sq_prod + (2*MAG_W)'(1 << 29)) >> 30);
         term_ff <= TERM_W'(mag_ff);
         sum_ff  <= '0;
         cnt_ff  <= '0;
      end
      if (cmd.check && st.go) begin
         if (neg_ff ^ cnt_ff[0]) sum_ff <= sum_ff - SUM_W'(term_ff);
         else sum_ff <= sum_ff + SUM_W'(term_ff);
      end
      if (cmd.mul_lo) acc_ff <= PROD_W'(part_prod);
      if (cmd.mul_hi) acc_ff <= acc_ff + (PROD_W'(part_prod) << HALF_W);
      if (cmd.div_load) begin
         num_ff <= NUM_W'(rnd >> 30) + NUM_W'(d >> 1);
         rem_ff <= '0;
      end
      if (cmd.div_step) begin
         num_ff <= {num_ff[NUM_W-3:0], b1, b2};
         rem_ff <= r2s;
      end
      if (cmd.div_done) begin
         term_ff <= num_ff[TERM_W-1:0];
         cnt_ff  <= cnt_ff + 1'b1;
      end
   end

   // result register: hold until the beat is taken
   always_ff @(posedge clock) begin
      if (reset) rsp_valid_ff <= 1'b0;
      else if (cmd.emit) rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         status_ff <= err_ff;
         if (err_ff != STAT_OK) begin
            sine_ff  <= '0;
            terms_ff <= '0;
         end else begin
            sine_ff  <= SINE_W'(sat);
            terms_ff <= cnt_ff + 1'b1;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_sine_value = sine_ff;
   assign rsp_terms_used = terms_ff;
   assign rsp_status     = status_ff;

endmodule

/* sv/taylor_sine_with_tolerance_core.sv */
// Taylor-series sine. Each req_ beat carries a signed Q10.20 angle; each
// rsp_ beat returns the Q1.30 sine (saturated to +-1.0), the term count and
// a status code (angle magnitude 1000 or more, or a zero tolerance, rejects
// the item). One item is in flight at a time; a rejected item skips the series,
// and an accepted one makes one pass per series term (up to MAX_TERMS) through
// the shared multiplier, split into two 17-bit halves, and the two-bits-per-cycle
// divider. The result register lets the next angle enter while a result waits.
// The tolerance (unsigned Q1.30, reset 1074) must be written over the csr_ port
// only while the block is idle; the block itself does not enforce this.
module taylor_sine_with_tolerance_core import tsin_pkg::*; #(
   parameter int MAX_TERMS = MAX_TERMS_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic signed [ANGLE_W-1:0] req_angle,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [SINE_W-1:0]  rsp_sine_value,
   output logic [CNT_W-1:0]          rsp_terms_used,
   output logic [STAT_W-1:0]         rsp_status,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [TOL_W-1:0]          csr_tolerance
);

   tsin_cmd_type  cmd;
   tsin_stat_type st;

   // always take a register write
   assign csr_ready = 1'b1;

   tsin_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .st        (st),
      .cmd       (cmd)
   );

   tsin_dp #(
      .MAX_TERMS (MAX_TERMS)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .st             (st),
      .req_angle      (req_angle),
      .csr_valid      (csr_valid),
      .csr_tolerance  (csr_tolerance),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_sine_value (rsp_sine_value),
      .rsp_terms_used (rsp_terms_used),
      .rsp_status     (rsp_status)
   );

endmodule
